// ----- sv/text_charset_detector_assert.svh -----
// Assertion helpers for the charset detector checker (tcd_checker).
`ifndef TEXT_CHARSET_DETECTOR_ASSERT_SVH
`define TEXT_CHARSET_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tcd_pkg.sv -----
package tcd_pkg;

	// Stream bookkeeping
	localparam int unsigned HeadDepth = 4;
	localparam logic [2:0]  SeenSat   = 3'd5;

	// Charset codes on both result fields
	typedef enum logic [2:0] {
		CS_UNKNOWN = 3'd0,
		CS_GBK     = 3'd1,
		CS_UTF8    = 3'd2,
		CS_UTF16LE = 3'd3,
		CS_UTF16BE = 3'd4
	} charset_t;

	// GBK byte ranges
	localparam logic [7:0] GbkLeadLo  = 8'h81;
	localparam logic [7:0] GbkHi      = 8'hFE;
	localparam logic [7:0] GbkTrailLo = 8'h40;

	// UTF-8 lead and continuation patterns (mask, value)
	localparam logic [7:0] Utf8ContMask  = 8'hC0;
	localparam logic [7:0] Utf8ContVal   = 8'h80;
	localparam logic [7:0] Utf8Lead2Mask = 8'hE0;
	localparam logic [7:0] Utf8Lead2Val  = 8'hC0;
	localparam logic [7:0] Utf8Lead3Mask = 8'hF0;
	localparam logic [7:0] Utf8Lead3Val  = 8'hE0;
	localparam logic [7:0] Utf8Lead4Mask = 8'hF8;
	localparam logic [7:0] Utf8Lead4Val  = 8'hF0;

	// UTF-16 surrogate high bytes
	localparam logic [7:0] SurMask = 8'hFC;
	localparam logic [7:0] SurHigh = 8'hD8;
	localparam logic [7:0] SurLow  = 8'hDC;

	// Byte order mark bytes
	localparam logic [7:0] BomEf = 8'hEF;
	localparam logic [7:0] BomBb = 8'hBB;
	localparam logic [7:0] BomBf = 8'hBF;
	localparam logic [7:0] BomFe = 8'hFE;
	localparam logic [7:0] BomFf = 8'hFF;
	localparam logic [7:0] BomZero = 8'h00;

	// Running state of one stream
	typedef struct packed {
		logic [HeadDepth-1:0][7:0] head;
		logic [2:0]                seen;
		logic                      gbk_want;
		logic                      gbk_bad;
		logic [1:0]                utf8_left;
		logic                      utf8_bad;
		logic                      odd;
		logic                      le_want;
		logic                      le_bad;
		logic                      be_want;
		logic                      be_bad;
	} stream_state_t;

endpackage

// ----- sv/tcd_tracker.sv -----
module tcd_tracker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output tcd_pkg::stream_state_t state_next
);
	import tcd_pkg::*;

	stream_state_t state_q;
	logic          is_high;
	logic          is_low;

	// Surrogate step for one UTF-16 lane: returns {want, bad}
	function automatic logic [1:0] unit_step(logic want, logic bad, logic hi_sur,
		logic lo_sur);
		logic [1:0] res;
		res = {want, bad};
		if (!bad) begin
			if (want) begin
				if (lo_sur) res = 2'b00;
				else        res = {want, 1'b1};
			end else if (hi_sur) begin
				res = 2'b10;
			end else if (lo_sur) begin
				res = 2'b01;
			end
		end
		return res;
	endfunction

	assign is_high = (data_byte & SurMask) == SurHigh;
	assign is_low  = (data_byte & SurMask) == SurLow;

	// Next stream state for the byte in flight
	always_comb begin
		state_next = state_q;

		// head capture and saturating count
		if (state_q.seen < 3'(HeadDepth)) begin
			state_next.head[state_q.seen[1:0]] = data_byte;
		end
		if (state_q.seen < SeenSat) begin
			state_next.seen = state_q.seen + 3'd1;
		end

		// GBK
		if (!state_q.gbk_bad) begin
			if (state_q.gbk_want) begin
				state_next.gbk_bad  = !(data_byte inside {[GbkTrailLo:GbkHi]});
				state_next.gbk_want = 1'b0;
			end else if (data_byte[7]) begin
				if (data_byte inside {[GbkLeadLo:GbkHi]}) state_next.gbk_want = 1'b1;
				else                                      state_next.gbk_bad  = 1'b1;
			end
		end

		// UTF-8
		if (!state_q.utf8_bad) begin
			if (state_q.utf8_left != 2'd0) begin
				if ((data_byte & Utf8ContMask) != Utf8ContVal) begin
					state_next.utf8_bad = 1'b1;
				end else begin
					state_next.utf8_left = state_q.utf8_left - 2'd1;
				end
			end else if (!data_byte[7]) begin
				state_next.utf8_left = 2'd0;
			end else if ((data_byte & Utf8Lead2Mask) == Utf8Lead2Val) begin
				state_next.utf8_left = 2'd1;
			end else if ((data_byte & Utf8Lead3Mask) == Utf8Lead3Val) begin
				state_next.utf8_left = 2'd2;
			end else if ((data_byte & Utf8Lead4Mask) == Utf8Lead4Val) begin
				state_next.utf8_left = 2'd3;
			end else begin
				state_next.utf8_bad = 1'b1;
			end
		end

		// UTF-16: odd-index bytes are LE high bytes, even-index are BE high bytes
		if (state_q.odd) begin
			{state_next.le_want, state_next.le_bad} =
				unit_step(state_q.le_want, state_q.le_bad, is_high, is_low);
		end else begin
			{state_next.be_want, state_next.be_bad} =
				unit_step(state_q.be_want, state_q.be_bad, is_high, is_low);
		end
		state_next.odd = !state_q.odd;
	end

	// State register, cleared after the last byte of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			if (last_byte) state_q <= '0;
			else           state_q <= state_next;
		end
	end

endmodule

// ----- sv/tcd_classify.sv -----
module tcd_classify (
	input  tcd_pkg::stream_state_t st,
	output tcd_pkg::charset_t      bom,
	output tcd_pkg::charset_t      content
);
	import tcd_pkg::*;

	logic is_utf32be;
	logic is_ff_fe_zero;
	logic is_utf8_bom;

	assign is_utf32be    = (st.head[0] == BomZero) && (st.head[1] == BomZero) &&
	                       (st.head[2] == BomFe) && (st.head[3] == BomFf);
	assign is_ff_fe_zero = (st.head[0] == BomFf) && (st.head[1] == BomFe) &&
	                       (st.head[2] == BomZero) && (st.head[3] == BomZero);
	assign is_utf8_bom   = (st.head[0] == BomEf) && (st.head[1] == BomBb) &&
	                       (st.head[2] == BomBf);

	// Byte order mark decode
	always_comb begin
		if (st.seen < 3'd2) begin
			bom = CS_UNKNOWN;
		end else if (st.seen >= 3'd4 && is_utf32be) begin
			bom = CS_UNKNOWN;
		end else if (st.seen >= 3'd4 && is_ff_fe_zero) begin
			bom = (st.seen == 3'd4) ? CS_UTF16LE : CS_UNKNOWN;
		end else if (st.seen >= 3'd3 && is_utf8_bom) begin
			bom = CS_UTF8;
		end else if (st.head[0] == BomFf && st.head[1] == BomFe) begin
			bom = CS_UTF16LE;
		end else if (st.head[0] == BomFe && st.head[1] == BomFf) begin
			bom = CS_UTF16BE;
		end else begin
			bom = CS_UNKNOWN;
		end
	end

	// Content charset by fixed priority; UTF-16 needs an even length
	always_comb begin
		if (!st.gbk_bad && !st.gbk_want) begin
			content = CS_GBK;
		end else if (!st.utf8_bad && st.utf8_left == 2'd0) begin
			content = CS_UTF8;
		end else if (!st.odd && !st.le_bad && !st.le_want) begin
			content = CS_UTF16LE;
		end else if (!st.odd && !st.be_bad && !st.be_want) begin
			content = CS_UTF16BE;
		end else begin
			content = CS_UNKNOWN;
		end
	end

endmodule

// ----- sv/text_charset_detector.sv -----
// Text charset detector.
// Input channel: one byte per transfer on data_byte, with last_byte set on the
// final byte of a stream. Output channel: one transfer per stream, carrying
// bom_charset (from a byte order mark) and content_charset (first of GBK,
// UTF-8, UTF-16LE, UTF-16BE whose rules the whole stream met).
// Bytes without last_byte produce no output transfer; they only update the
// running stream state, which returns to empty after each last byte.
// Throughput: one byte per cycle while in_stall is low. The per-byte
// validator update and the result decode sit between the input register
// and the output register. A last byte passes from the input register into
// the output register; out_valid stays high there until the result transfers.
// When out_stall is high the output register holds its result; bytes that are
// not last keep flowing, and in_stall rises only while the input register
// holds a last byte that cannot move into the occupied output register.
// Reset (arst_n low) empties both registers and clears the stream state;
// the first byte after reset starts a new stream.
module text_charset_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bom_charset,
	output logic [2:0] content_charset
);
	import tcd_pkg::*;

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic          advance;
	logic          valid_s2;
	charset_t      bom_s2;
	charset_t      content_s2;
	stream_state_t state_next;
	charset_t      bom_next;
	charset_t      content_next;

	// Input register moves on unless a last byte finds the output register blocked
	assign advance  = valid_s1 && (!last_s1 || !valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	tcd_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.state_next (state_next)
	);

	tcd_classify u_classify (
		.st      (state_next),
		.bom     (bom_next),
		.content (content_next)
	);

	// Output register: loads on a last byte, empties on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			bom_s2     <= bom_next;
			content_s2 <= content_next;
		end
	end

	assign out_valid       = valid_s2;
	assign bom_charset     = bom_s2;
	assign content_charset = content_s2;

endmodule

// ----- sv/tcd_checker.sv -----
`include "text_charset_detector_assert.svh"

module tcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] bom_charset,
	input logic [2:0] content_charset
);
	import tcd_pkg::*;

	logic       held;
	logic [5:0] out_word;
	logic       bom_ok;
	logic       content_ok;

	assign held     = out_valid && out_stall;
	assign out_word = {bom_charset, content_charset};

	// a byte order mark never names GBK or a code beyond UTF-16BE
	assign bom_ok     = bom_charset inside {CS_UNKNOWN, CS_UTF8, CS_UTF16LE, CS_UTF16BE};
	assign content_ok = content_charset <= CS_UTF16BE;

	// a stalled result stays put
	`TCD_ASSERT_NEXT(a_out_hold, clk, arst_n, held, out_valid && $stable(out_word), "held result moved")

	// bom code is one of the defined marks
	`TCD_ASSERT_IMPLY(a_bom_code, clk, arst_n, out_valid, bom_ok, "illegal bom_charset")

	// content code stays within the defined charsets
	`TCD_ASSERT_IMPLY(a_content_code, clk, arst_n, out_valid, content_ok, "illegal content_charset")

	// the input side only stalls while output is backed up
	`TCD_ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, held, "input stalled with output free")

endmodule

bind text_charset_detector tcd_checker u_tcd_checker (.*);

// ----- tb/text_charset_detector_checker.sv -----
`timescale 1ns / 1ps
module text_charset_detector_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] bom_charset,
	input  logic [2:0] content_charset,
	input  logic       run_done,
	output int         outstanding,
	output int         results_checked,
	output int         fail_count
);
	import tcd_pkg::*;

	// One result transfer: both charset verdicts of a stream
	typedef struct packed {
		charset_t bom;
		charset_t content;
	} verdict_t;

	verdict_t expected_verdicts[$];
	verdict_t got_verdict;

	// Running stream state of the predictor
	logic [7:0] head_q [4];
	logic [2:0] seen_n;
	logic       gbk_trail_due;
	logic       gbk_fail;
	logic [1:0] utf8_due;
	logic       utf8_fail;
	logic       odd_pos;
	logic       le_low_due;
	logic       le_fail;
	logic       be_low_due;
	logic       be_fail;

	task report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 30)
			$display("[%0t] checker: %s", $time, msg);
	endtask

	task clear_stream();
		for (int k = 0; k < 4; k++)
			head_q[k] = 8'h00;
		seen_n = 3'd0;
		gbk_trail_due = 1'b0;
		gbk_fail = 1'b0;
		utf8_due = 2'd0;
		utf8_fail = 1'b0;
		odd_pos = 1'b0;
		le_low_due = 1'b0;
		le_fail = 1'b0;
		be_low_due = 1'b0;
		be_fail = 1'b0;
	endtask

	// Surrogate pairing on the high byte of one 16-bit unit
	task check_unit(input logic [7:0] hi, inout logic want, inout logic bad);
		if (!bad) begin
			if (want) begin
				if ((hi & SurMask) == SurLow)
					want = 1'b0;
				else
					bad = 1'b1;
			end else if ((hi & SurMask) == SurHigh) begin
				want = 1'b1;
			end else if ((hi & SurMask) == SurLow) begin
				bad = 1'b1;
			end
		end
	endtask

	function charset_t stream_bom();
		if (seen_n < 3'd2)
			return CS_UNKNOWN;
		// UTF-32BE mark is reported as unknown
		if (seen_n >= 3'd4 && head_q[0] == BomZero && head_q[1] == BomZero &&
			head_q[2] == BomFe && head_q[3] == BomFf)
			return CS_UNKNOWN;
		// FF FE 00 00 counts as UTF-16LE only for a four-byte stream
		if (seen_n >= 3'd4 && head_q[0] == BomFf && head_q[1] == BomFe &&
			head_q[2] == BomZero && head_q[3] == BomZero)
			return (seen_n == 3'd4) ? CS_UTF16LE : CS_UNKNOWN;
		if (seen_n >= 3'd3 && head_q[0] == BomEf && head_q[1] == BomBb && head_q[2] == BomBf)
			return CS_UTF8;
		if (head_q[0] == BomFf && head_q[1] == BomFe)
			return CS_UTF16LE;
		if (head_q[0] == BomFe && head_q[1] == BomFf)
			return CS_UTF16BE;
		return CS_UNKNOWN;
	endfunction

	// Priority: GBK, UTF-8, UTF-16LE, UTF-16BE
	function charset_t stream_content();
		if (!gbk_fail && !gbk_trail_due)
			return CS_GBK;
		if (!utf8_fail && utf8_due == 2'd0)
			return CS_UTF8;
		if (!odd_pos && !le_fail && !le_low_due)
			return CS_UTF16LE;
		if (!odd_pos && !be_fail && !be_low_due)
			return CS_UTF16BE;
		return CS_UNKNOWN;
	endfunction

	task absorb_byte(input logic [7:0] b, input logic fin);
		verdict_t verdict;
		if (seen_n < 3'd4)
			head_q[seen_n[1:0]] = b;
		if (seen_n < SeenSat)
			seen_n = seen_n + 3'd1;

		// GBK: lead 81..FE, trail 40..FE
		if (!gbk_fail) begin
			if (gbk_trail_due) begin
				if (b < GbkTrailLo || b > GbkHi)
					gbk_fail = 1'b1;
				gbk_trail_due = 1'b0;
			end else if (b[7]) begin
				if (b < GbkLeadLo || b > GbkHi)
					gbk_fail = 1'b1;
				else
					gbk_trail_due = 1'b1;
			end
		end

		// UTF-8 sequence length tracking
		if (!utf8_fail) begin
			if (utf8_due != 2'd0) begin
				if ((b & Utf8ContMask) != Utf8ContVal)
					utf8_fail = 1'b1;
				else
					utf8_due = utf8_due - 2'd1;
			end else if (b[7]) begin
				if ((b & Utf8Lead2Mask) == Utf8Lead2Val)
					utf8_due = 2'd1;
				else if ((b & Utf8Lead3Mask) == Utf8Lead3Val)
					utf8_due = 2'd2;
				else if ((b & Utf8Lead4Mask) == Utf8Lead4Val)
					utf8_due = 2'd3;
				else
					utf8_fail = 1'b1;
			end
		end

		// odd index carries the LE high byte, even index the BE high byte
		if (odd_pos)
			check_unit(b, le_low_due, le_fail);
		else
			check_unit(b, be_low_due, be_fail);
		odd_pos = !odd_pos;

		if (fin) begin
			verdict.bom = stream_bom();
			verdict.content = stream_content();
			expected_verdicts.insert(expected_verdicts.size(), verdict);
			clear_stream();
		end
	endtask

	// Compare output transfers first, then fold in the input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stream();
			expected_verdicts.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result bom=%0d content=%0d",
						bom_charset, content_charset));
				end else begin
					got_verdict = expected_verdicts.pop_front();
					results_checked++;
					if (bom_charset !== got_verdict.bom)
						report_mismatch($sformatf("bom_charset %0d, expected %0d",
							bom_charset, got_verdict.bom));
					if (content_charset !== got_verdict.content)
						report_mismatch($sformatf("content_charset %0d, expected %0d",
							content_charset, got_verdict.content));
				end
			end
			if (in_valid && !in_stall)
				absorb_byte(data_byte, last_byte);
			if (run_done) begin
				while (expected_verdicts.size() != 0) begin
					got_verdict = expected_verdicts.pop_front();
					report_mismatch($sformatf("result never arrived: bom=%0d content=%0d",
						got_verdict.bom, got_verdict.content));
				end
			end
			outstanding <= expected_verdicts.size();
		end
	end

endmodule

// ----- tb/text_charset_detector_tb.sv -----
`timescale 1ns / 1ps
module text_charset_detector_tb;
	import tcd_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int ByteTarget = 800;

	typedef enum int {
		BODY_GBK,
		BODY_UTF8,
		BODY_LE,
		BODY_BE,
		BODY_NOISE
	} body_kind_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] bom_charset;
	logic [2:0] content_charset;
	logic       run_done = 1'b0;
	logic       idle_on = 1'b0;

	int outstanding;
	int results_checked;
	int fail_count;
	int cycle_count = 0;
	int stall_hold = 0;
	int byte_total = 0;
	int stream_total = 0;
	int fast_streams = 0;

	logic [7:0] stream_q[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	text_charset_detector u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.bom_charset     (bom_charset),
		.content_charset (content_charset)
	);

	text_charset_detector_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.bom_charset     (bom_charset),
		.content_charset (content_charset),
		.run_done        (run_done),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.fail_count      (fail_count)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("run timed out after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: with idle_on, random stalls after transfers and stray stalls while out_valid is low
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				stall_hold = idle_on ? $urandom_range(0, 12) : 0;
				if (stall_hold > 0)
					out_stall <= 1'b1;
			end else if (stall_hold > 0) begin
				stall_hold--;
				if (stall_hold == 0)
					out_stall <= 1'b0;
			end else if (idle_on && !out_valid && $urandom_range(0, 15) == 0) begin
				stall_hold = $urandom_range(1, 12);
				out_stall <= 1'b1;
			end
		end
	end

	task send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (in_stall);
		byte_total++;
	endtask

	task send_stream();
		if (!idle_on)
			fast_streams++;
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
		stream_total++;
	endtask

	// Hold off the sender until every pending result has been taken
	task drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Add one byte at the end of the stream being built
	task append_byte(input logic [7:0] b);
		stream_q.insert(stream_q.size(), b);
	endtask

	// Directed streams, first byte in the most significant used lane
	task load_packed(input logic [47:0] bytes, input int n);
		stream_q.delete();
		for (int i = n - 1; i >= 0; i--)
			append_byte(bytes[8*i +: 8]);
	endtask

	task add_unit16(input logic little, input logic [7:0] hi, input logic [7:0] lo);
		if (little) begin
			append_byte(lo);
			append_byte(hi);
		end else begin
			append_byte(hi);
			append_byte(lo);
		end
	endtask

	// Well-formed characters of one encoding, or plain noise
	task add_body(input body_kind_t kind, input int count);
		logic [7:0] hi;
		logic [7:0] lo;
		int n;
		for (int i = 0; i < count; i++) begin
			case (kind)
			BODY_GBK: begin
				if ($urandom_range(0, 1)) begin
					hi = 8'($urandom_range(0, 127));
					append_byte(hi);
				end else begin
					hi = 8'($urandom_range(GbkLeadLo, GbkHi));
					lo = 8'($urandom_range(GbkTrailLo, GbkHi));
					append_byte(hi);
					append_byte(lo);
				end
			end
			BODY_UTF8: begin
				n = $urandom_range(0, 3);
				hi = 8'($urandom);
				case (n)
				0: hi[7] = 1'b0;
				1: hi = (hi & ~Utf8Lead2Mask) | Utf8Lead2Val;
				2: hi = (hi & ~Utf8Lead3Mask) | Utf8Lead3Val;
				default: hi = (hi & ~Utf8Lead4Mask) | Utf8Lead4Val;
				endcase
				append_byte(hi);
				repeat (n) begin
					hi = 8'($urandom);
					hi = (hi & ~Utf8ContMask) | Utf8ContVal;
					append_byte(hi);
				end
			end
			BODY_LE, BODY_BE: begin
				lo = 8'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					hi = 8'($urandom);
					add_unit16(kind == BODY_LE, (hi & ~SurMask) | SurHigh, lo);
					hi = 8'($urandom);
					lo = 8'($urandom);
					add_unit16(kind == BODY_LE, (hi & ~SurMask) | SurLow, lo);
				end else begin
					do hi = 8'($urandom);
					while ((hi & SurMask) == SurHigh || (hi & SurMask) == SurLow);
					add_unit16(kind == BODY_LE, hi, lo);
				end
			end
			default: begin
				hi = 8'($urandom);
				append_byte(hi);
			end
			endcase
		end
	endtask

	// Mostly well-formed bodies, some behind a BOM, some damaged, some noise
	task build_stream();
		int pick;
		int spot;
		logic [7:0] junk;
		body_kind_t kind;
		stream_q.delete();
		kind = body_kind_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 19);
		if (pick < 4) begin
			case ($urandom_range(0, 4))
			0: begin
				append_byte(BomEf);
				append_byte(BomBb);
				append_byte(BomBf);
			end
			1: begin
				append_byte(BomFf);
				append_byte(BomFe);
			end
			2: begin
				append_byte(BomFe);
				append_byte(BomFf);
			end
			3: begin
				append_byte(BomZero);
				append_byte(BomZero);
				append_byte(BomFe);
				append_byte(BomFf);
			end
			default: begin
				append_byte(BomFf);
				append_byte(BomFe);
				append_byte(BomZero);
				append_byte(BomZero);
			end
			endcase
			add_body(kind, $urandom_range(0, 4));
		end else if (pick < 6) begin
			add_body(BODY_NOISE, $urandom_range(1, 8));
		end else if (pick < 9) begin
			// truncate or corrupt one byte
			add_body(kind, $urandom_range(1, 6));
			if ($urandom_range(0, 1)) begin
				junk = stream_q.pop_back();
			end else begin
				spot = $urandom_range(0, stream_q.size() - 1);
				junk = 8'($urandom);
				stream_q[spot] = junk;
			end
		end else if (pick == 9) begin
			add_body(kind, $urandom_range(20, 40));
		end else begin
			add_body(kind, $urandom_range(1, 6));
		end
		if (stream_q.size() == 0) begin
			junk = 8'($urandom);
			append_byte(junk);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;
		@(posedge clk);

		// single byte, UTF-32BE mark, four-byte and longer FF FE 00 00,
		// UTF-8 mark, UTF-16BE mark, stray low surrogate on the LE side
		load_packed(48'h41, 1);
		send_stream();
		load_packed(48'h0000FEFF, 4);
		send_stream();
		load_packed(48'hFFFE0000, 4);
		send_stream();
		load_packed(48'hFFFE00004100, 6);
		send_stream();
		load_packed(48'hEFBBBF, 3);
		send_stream();
		load_packed(48'hFEFF, 2);
		send_stream();
		load_packed(48'h00DC00D8, 4);
		send_stream();
		drain_results();

		while (byte_total < ByteTarget) begin
			if (stream_total % 10 == 0)
				idle_on <= ($urandom_range(0, 3) != 0);
			if (stream_total == 60)
				drain_results();
			build_stream();
			send_stream();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d streams / %0d bytes, %0d results checked, %0d streams without idling",
			stream_total, byte_total, results_checked, fast_streams);
		$display("mix: BOM heads, valid GBK/UTF-8/UTF-16 bodies, damaged and noise streams");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- text_charset_detector.f -----
+incdir+sv
sv/tcd_pkg.sv
sv/tcd_tracker.sv
sv/tcd_classify.sv
sv/text_charset_detector.sv
sv/tcd_checker.sv
tb/text_charset_detector_checker.sv
tb/text_charset_detector_tb.sv
